// ===== rtl/maze_wall_union_find_defines.svh =====
// Assertion macros shared by the maze builder modules.
// The modules that use them provide clk and rst_n.
`ifndef MAZE_WALL_UNION_FIND_DEFINES_SVH
`define MAZE_WALL_UNION_FIND_DEFINES_SVH

`define MWUF_ASSERT_IMPL(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("maze builder check failed");

`define MWUF_ASSERT_NEXT(name, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("maze builder check failed");

`endif

// ===== rtl/mwuf_pkg.sv =====
`default_nettype none

package mwuf_pkg;

    localparam int GRID_SIDE_DEF = 13;

    typedef struct packed {
        logic       action;
        logic [3:0] wall_row;
        logic [3:0] wall_col;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       maze_done;
    } out_item_t;

    localparam logic ACT_RESTART = 1'b0;
    localparam logic ACT_OFFER   = 1'b1;

    typedef logic [1:0] status_t;
    localparam status_t ST_NOT_WALL = 2'd0;
    localparam status_t ST_KEPT     = 2'd1;
    localparam status_t ST_REMOVED  = 2'd2;
    localparam status_t ST_RESTART  = 2'd3;

    typedef logic [2:0] rd_sel_t;
    localparam rd_sel_t RD_NONE   = 3'd0;
    localparam rd_sel_t RD_WALL   = 3'd1;
    localparam rd_sel_t RD_A      = 3'd2;
    localparam rd_sel_t RD_B      = 3'd3;
    localparam rd_sel_t RD_START  = 3'd4;
    localparam rd_sel_t RD_LAST   = 3'd5;
    localparam rd_sel_t RD_FOLLOW = 3'd6;

    typedef logic [2:0] wr_sel_t;
    localparam wr_sel_t WR_NONE  = 3'd0;
    localparam wr_sel_t WR_CLEAR = 3'd1;
    localparam wr_sel_t WR_WALL  = 3'd2;
    localparam wr_sel_t WR_CHILD = 3'd3;
    localparam wr_sel_t WR_RANK  = 3'd4;

    typedef struct packed {
        logic    latch_item;
        logic    calc_idx;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    cap_root_a;
        logic    cap_root_b;
        logic    cap_root_s;
        logic    cap_done;
        logic    load_out;
        status_t out_status;
    } mwuf_cmd_t;

    typedef struct packed {
        logic in_action;
        logic clr_last;
        logic addr_ok;
        logic rd_removed;
        logic rd_root;
        logic roots_equal;
        logic ranks_equal;
        logic out_busy;
    } mwuf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/maze_wall_union_find.sv =====
// Maze wall remover over a disjoint-set forest of the grid positions.
// Input channel (wall_valid, wall_ready, wall_item): action 0 restarts the
// maze, action 1 offers the wall at (wall_row, wall_col). Output channel
// (result_valid, result_ready, result_item): one result per input transfer,
// with the outcome status and whether the start and end cells are joined.
// One item is worked at a time through a single table memory with one write
// and one registered read port. A position off the wall pattern is settled
// from the index alone and a wall already removed after one table read. A
// kept wall takes the two root walks; a removed wall takes them too, then
// writes the wall and the child link, bumps the rank when the ranks tie,
// and walks from the start and the end cell. Each walk reads one entry per
// parent link under union by rank. A restart sweeps the whole table at one
// entry per cycle before its result is loaded. wall_ready rises together
// with result_valid, so the next transfer can be taken while that result
// is still offered. After reset the same sweep runs before wall_ready
// first rises. The result sits in an output register; while the receiver
// stalls, the next item may be taken and worked, and it waits only to load
// its own result.
`default_nettype none

module maze_wall_union_find
    import mwuf_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wall_valid,
    output logic      wall_ready,
    input  in_item_t  wall_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    mwuf_cmd_t  cmd;
    mwuf_stat_t stat;

    mwuf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .wall_valid(wall_valid),
        .wall_ready(wall_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mwuf_datapath #(
        .GRID_SIDE(GRID_SIDE)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .wall_item   (wall_item),
        .result_ready(result_ready),
        .result_valid(result_valid),
        .result_item (result_item),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ===== rtl/mwuf_ram.sv =====
`default_nettype none

module mwuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mwuf_ctrl.sv =====
`default_nettype none
`include "maze_wall_union_find_defines.svh"

module mwuf_ctrl
    import mwuf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wall_valid,
    output logic       wall_ready,
    input  mwuf_stat_t stat,
    output mwuf_cmd_t  cmd
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_INDEX   = 4'd2;
    localparam logic [3:0] S_RDWALL  = 4'd3;
    localparam logic [3:0] S_CHKWALL = 4'd4;
    localparam logic [3:0] S_WALKA   = 4'd5;
    localparam logic [3:0] S_WALKB   = 4'd6;
    localparam logic [3:0] S_DECIDE  = 4'd7;
    localparam logic [3:0] S_JOIN    = 4'd8;
    localparam logic [3:0] S_RANK    = 4'd9;
    localparam logic [3:0] S_RDSTART = 4'd10;
    localparam logic [3:0] S_WALKS   = 4'd11;
    localparam logic [3:0] S_WALKE   = 4'd12;
    localparam logic [3:0] S_FINISH  = 4'd13;

    logic [3:0] state_reg, state_next;
    logic       restart_reg, restart_next;
    status_t    status_reg, status_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            restart_reg <= 1'b0;
            status_reg  <= ST_NOT_WALL;
        end
        else
        begin
            state_reg   <= state_next;
            restart_reg <= restart_next;
            status_reg  <= status_next;
        end
    end

    assign wall_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        restart_next   = restart_reg;
        status_next    = status_reg;
        cmd            = '0;
        cmd.rd_sel     = RD_NONE;
        cmd.wr_sel     = WR_NONE;
        cmd.out_status = status_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_sel = WR_CLEAR;
                if (stat.clr_last)
                begin
                    restart_next = 1'b0;
                    status_next  = ST_RESTART;
                    state_next   = restart_reg ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (wall_valid)
                begin
                    cmd.latch_item = 1'b1;
                    if (stat.in_action == ACT_RESTART)
                    begin
                        restart_next = 1'b1;
                        state_next   = S_CLEAR;
                    end
                    else
                    begin
                        state_next = S_INDEX;
                    end
                end
            end
            S_INDEX:
            begin
                cmd.calc_idx = 1'b1;
                state_next   = S_RDWALL;
            end
            S_RDWALL:
            begin
                if (!stat.addr_ok)
                begin
                    status_next = ST_NOT_WALL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_WALL;
                    state_next = S_CHKWALL;
                end
            end
            S_CHKWALL:
            begin
                if (stat.rd_removed)
                begin
                    status_next = ST_NOT_WALL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_A;
                    state_next = S_WALKA;
                end
            end
            S_WALKA:
            begin
                if (stat.rd_root)
                begin
                    cmd.cap_root_a = 1'b1;
                    cmd.rd_sel     = RD_B;
                    state_next     = S_WALKB;
                end
                else
                begin
                    cmd.rd_sel = RD_FOLLOW;
                end
            end
            S_WALKB:
            begin
                if (stat.rd_root)
                begin
                    cmd.cap_root_b = 1'b1;
                    state_next     = S_DECIDE;
                end
                else
                begin
                    cmd.rd_sel = RD_FOLLOW;
                end
            end
            S_DECIDE:
            begin
                if (stat.roots_equal)
                begin
                    status_next = ST_KEPT;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.wr_sel = WR_WALL;
                    state_next = S_JOIN;
                end
            end
            S_JOIN:
            begin
                cmd.wr_sel = WR_CHILD;
                state_next = stat.ranks_equal ? S_RANK : S_RDSTART;
            end
            S_RANK:
            begin
                cmd.wr_sel = WR_RANK;
                state_next = S_RDSTART;
            end
            S_RDSTART:
            begin
                cmd.rd_sel = RD_START;
                state_next = S_WALKS;
            end
            S_WALKS:
            begin
                if (stat.rd_root)
                begin
                    cmd.cap_root_s = 1'b1;
                    cmd.rd_sel     = RD_LAST;
                    state_next     = S_WALKE;
                end
                else
                begin
                    cmd.rd_sel = RD_FOLLOW;
                end
            end
            S_WALKE:
            begin
                if (stat.rd_root)
                begin
                    cmd.cap_done = 1'b1;
                    status_next  = ST_REMOVED;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.rd_sel = RD_FOLLOW;
                end
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `MWUF_ASSERT_NEXT(a_clear_exit, state_reg == S_CLEAR && stat.clr_last,
        state_reg == S_IDLE || state_reg == S_FINISH)
    `MWUF_ASSERT_NEXT(a_restart_reports, state_reg == S_CLEAR && stat.clr_last && restart_reg,
        status_reg == ST_RESTART)

endmodule

`default_nettype wire

// ===== rtl/mwuf_datapath.sv =====
`default_nettype none
`include "maze_wall_union_find_defines.svh"

module mwuf_datapath
    import mwuf_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   wall_item,
    input  logic       result_ready,
    output logic       result_valid,
    output out_item_t  result_item,
    input  mwuf_cmd_t  cmd,
    output mwuf_stat_t stat
);

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam int ENT_W      = IDX_W + 2;
    localparam int PROD_W     = IDX_W + 4;
    localparam int CMP_W      = (($clog2(GRID_SIDE + 1) > 4) ? $clog2(GRID_SIDE + 1) : 4) + 1;
    localparam logic [CMP_W-1:0] SIDE_C   = CMP_W'(GRID_SIDE);
    localparam logic [IDX_W-1:0] SIDE_I   = IDX_W'(GRID_SIDE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);
    localparam logic [IDX_W-1:0] RANK_ONE = IDX_W'(1);

    in_item_t         item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             odd_reg;
    logic             ok_reg;
    logic [IDX_W-1:0] cur_reg;
    logic [IDX_W-1:0] root_a_reg, rank_a_reg;
    logic [IDX_W-1:0] root_b_reg, rank_b_reg;
    logic [IDX_W-1:0] root_s_reg;
    logic             done_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             result_valid_reg;
    out_item_t        result_reg;

    logic [CMP_W-1:0]  row_x, col_x;
    logic              in_range, pat_wall;
    logic [3:0]        row_m1, col_m1;
    logic [PROD_W-1:0] idx_sum;
    logic [IDX_W-1:0]  a_idx, b_idx;

    logic             re, we;
    logic [IDX_W-1:0] raddr, waddr;
    logic [ENT_W-1:0] wdata, rdata;
    logic [IDX_W-1:0] rd_pay;
    logic             a_wins;
    logic [IDX_W-1:0] rank_inc;
    logic             out_busy;

    assign row_x    = CMP_W'(item_reg.wall_row);
    assign col_x    = CMP_W'(item_reg.wall_col);
    assign in_range = (row_x != '0) && (row_x <= SIDE_C) && (col_x != '0) && (col_x <= SIDE_C);
    assign pat_wall = item_reg.wall_row[0]
                    ? (!item_reg.wall_col[0] && (col_x + CMP_W'(1) <= SIDE_C))
                    : (item_reg.wall_col[0] && (row_x + CMP_W'(1) <= SIDE_C));
    assign row_m1   = item_reg.wall_row - 4'd1;
    assign col_m1   = item_reg.wall_col - 4'd1;
    assign idx_sum  = PROD_W'(row_m1) * PROD_W'(SIDE_I) + PROD_W'(col_m1);

    assign a_idx = odd_reg ? idx_reg + RANK_ONE : idx_reg + SIDE_I;
    assign b_idx = odd_reg ? idx_reg - RANK_ONE : idx_reg - SIDE_I;

    assign rd_pay   = rdata[IDX_W-1:0];
    assign a_wins   = (rank_a_reg >= rank_b_reg);
    assign rank_inc = (rank_a_reg == '1) ? rank_a_reg : rank_a_reg + RANK_ONE;
    assign out_busy = result_valid_reg && !result_ready;

    always_comb
    begin
        re = (cmd.rd_sel != RD_NONE);
        case (cmd.rd_sel)
            RD_WALL:   raddr = idx_reg;
            RD_A:      raddr = a_idx;
            RD_B:      raddr = b_idx;
            RD_START:  raddr = '0;
            RD_LAST:   raddr = LAST_IDX;
            RD_FOLLOW: raddr = rd_pay;
            default:   raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        waddr = clr_cnt_reg;
        wdata = {1'b0, 1'b1, RANK_ONE};
        case (cmd.wr_sel)
            WR_CLEAR:
            begin
                waddr = clr_cnt_reg;
                wdata = {1'b0, 1'b1, RANK_ONE};
            end
            WR_WALL:
            begin
                waddr = idx_reg;
                wdata = {1'b1, 1'b1, RANK_ONE};
            end
            WR_CHILD:
            begin
                waddr = a_wins ? root_b_reg : root_a_reg;
                wdata = {1'b0, 1'b0, (a_wins ? root_a_reg : root_b_reg)};
            end
            WR_RANK:
            begin
                waddr = root_a_reg;
                wdata = {1'b0, 1'b1, rank_inc};
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    mwuf_ram #(
        .WIDTH(ENT_W),
        .DEPTH(CELL_COUNT)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            item_reg <= wall_item;
        end
        if (cmd.calc_idx)
        begin
            idx_reg <= idx_sum[IDX_W-1:0];
            odd_reg <= item_reg.wall_row[0];
            ok_reg  <= in_range && pat_wall;
        end
        if (re)
        begin
            cur_reg <= raddr;
        end
        if (cmd.cap_root_a)
        begin
            root_a_reg <= cur_reg;
            rank_a_reg <= rd_pay;
        end
        if (cmd.cap_root_b)
        begin
            root_b_reg <= cur_reg;
            rank_b_reg <= rd_pay;
        end
        if (cmd.cap_root_s)
        begin
            root_s_reg <= cur_reg;
        end
        if (cmd.load_out)
        begin
            result_reg.status    <= cmd.out_status;
            result_reg.maze_done <= done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg      <= '0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_sel == WR_CLEAR)
            begin
                clr_cnt_reg <= (clr_cnt_reg == LAST_IDX) ? '0 : clr_cnt_reg + RANK_ONE;
                done_reg    <= 1'b0;
            end
            else if (cmd.cap_done)
            begin
                done_reg <= (cur_reg == root_s_reg);
            end
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

    assign stat.in_action   = wall_item.action;
    assign stat.clr_last    = (clr_cnt_reg == LAST_IDX);
    assign stat.addr_ok     = ok_reg;
    assign stat.rd_removed  = rdata[IDX_W+1];
    assign stat.rd_root     = rdata[IDX_W];
    assign stat.roots_equal = (root_a_reg == root_b_reg);
    assign stat.ranks_equal = (rank_a_reg == rank_b_reg);
    assign stat.out_busy    = out_busy;

    `MWUF_ASSERT_NEXT(a_done_holds, done_reg && cmd.wr_sel != WR_CLEAR, done_reg)
    `MWUF_ASSERT_IMPL(a_wall_needs_two_roots, cmd.wr_sel == WR_WALL,
        root_a_reg != root_b_reg)
    `MWUF_ASSERT_IMPL(a_capture_on_root, cmd.cap_root_a || cmd.cap_root_b || cmd.cap_root_s,
        rdata[IDX_W])
    `MWUF_ASSERT_IMPL(a_load_slot_free, cmd.load_out, !out_busy)

endmodule

`default_nettype wire

// ===== tb/sv/maze_wall_union_find_tb.sv =====
`default_nettype none

module maze_wall_union_find_tb;
    import mwuf_pkg::*;

    localparam int SIDE = GRID_SIDE_DEF;
    localparam int CELLS = SIDE * SIDE;
    localparam int RANDOM_PER_PHASE = 135;
    localparam int LONG_HOLD = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [1:0] KIND_OPEN  = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_JOINT = 2'd2;

    class maze_scoreboard;
        int         parent_link [CELLS];
        logic [1:0] grid_kind [CELLS];
        out_item_t  results_due [$];
        int         errors;

        function new();
            errors = 0;
            rebuild_maze();
        endfunction

        function int pos_index(int r, int c);
            return (r - 1) * SIDE + (c - 1);
        endfunction

        function void rebuild_maze();
            for (int r = 1; r <= SIDE; r++)
            begin
                for (int c = 1; c <= SIDE; c++)
                begin
                    if (r % 2 == 1)
                        grid_kind[pos_index(r, c)] =
                            (c % 2 == 0 && c + 1 <= SIDE) ? KIND_WALL : KIND_OPEN;
                    else
                        grid_kind[pos_index(r, c)] = (c % 2 == 1) ? KIND_WALL : KIND_JOINT;
                    parent_link[pos_index(r, c)] = -1;
                end
            end
        endfunction

        // Walks to the root, then points every node on the path straight at it.
        function int root_of(int x);
            int root;
            int cur;
            int nxt;
            int steps;
            root = x;
            steps = 0;
            while (parent_link[root] >= 0 && steps < CELLS)
            begin
                if (parent_link[root] >= CELLS)
                    break;
                root = parent_link[root];
                steps++;
            end
            cur = x;
            steps = 0;
            while (cur != root && parent_link[cur] >= 0 && steps < CELLS)
            begin
                nxt = parent_link[cur];
                if (nxt >= CELLS)
                    break;
                parent_link[cur] = root;
                cur = nxt;
                steps++;
            end
            return root;
        endfunction

        function void join_roots(int a, int b);
            int rank_a;
            int rank_b;
            rank_a = parent_link[a];
            rank_b = parent_link[b];
            if (rank_a < rank_b)
                parent_link[b] = a;
            else if (rank_a == rank_b)
            begin
                if (parent_link[a] > -CELLS)
                    parent_link[a] = parent_link[a] - 1;
                parent_link[b] = a;
            end
            else
                parent_link[a] = b;
        endfunction

        function out_item_t step_maze(in_item_t item);
            out_item_t res;
            int r;
            int c;
            int r1;
            int c1;
            int r2;
            int c2;
            int a;
            int b;
            r = int'(item.wall_row);
            c = int'(item.wall_col);
            res.status = ST_NOT_WALL;
            if (item.action == ACT_RESTART)
            begin
                rebuild_maze();
                res.status = ST_RESTART;
            end
            else if (r >= 1 && r <= SIDE && c >= 1 && c <= SIDE &&
                     grid_kind[pos_index(r, c)] == KIND_WALL)
            begin
                if (r % 2 == 1)
                begin
                    r1 = r;
                    c1 = c + 1;
                    r2 = r;
                    c2 = c - 1;
                end
                else
                begin
                    r1 = r + 1;
                    c1 = c;
                    r2 = r - 1;
                    c2 = c;
                end
                if (r1 >= 1 && r1 <= SIDE && c1 >= 1 && c1 <= SIDE &&
                    r2 >= 1 && r2 <= SIDE && c2 >= 1 && c2 <= SIDE)
                begin
                    a = root_of(pos_index(r1, c1));
                    b = root_of(pos_index(r2, c2));
                    if (a != b)
                    begin
                        grid_kind[pos_index(r, c)] = KIND_OPEN;
                        join_roots(a, b);
                        res.status = ST_REMOVED;
                    end
                    else
                        res.status = ST_KEPT;
                end
            end
            res.maze_done = (root_of(0) == root_of(CELLS - 1));
            return res;
        endfunction

        function void note_transfer(in_item_t item);
            results_due.push_back(step_maze(item));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result status %0d maze_done %0d",
                         $time, got.status, got.maze_done);
                errors++;
                return;
            end
            want = results_due.pop_front();
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0d actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.maze_done !== want.maze_done)
            begin
                $display("%0t: maze_done expected %0d actual %0d",
                         $time, want.maze_done, got.maze_done);
                errors++;
            end
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      wall_valid = 1'b0;
    logic      wall_ready;
    in_item_t  wall_item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result_item;

    maze_scoreboard sb;
    int tx_idle_pct = 33;
    int rx_idle_pct = 52;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    maze_wall_union_find DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .wall_valid   (wall_valid),
        .wall_ready   (wall_ready),
        .wall_item    (wall_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (result_valid && result_ready)
            sb.check_result(result_item);
        if (hold_asked != hold_served)
        begin
            hold_served <= hold_asked;
            hold_left <= LONG_HOLD;
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((wall_valid && wall_ready) || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("maze_wall_union_find_tb NOT OK");
            $finish;
        end
    end

    task automatic send_item(in_item_t item);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            wall_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        wall_valid <= 1'b1;
        wall_item <= item;
        do
            @(posedge clk);
        while (!wall_ready);
        sb.note_transfer(item);
    endtask

    task automatic send_fields(logic action, int r, int c);
        in_item_t item;
        item.action = action;
        item.wall_row = r[3:0];
        item.wall_col = c[3:0];
        send_item(item);
    endtask

    task automatic send_random_item();
        in_item_t item;
        int roll;
        roll = $urandom_range(99);
        item.action = ACT_OFFER;
        if ($urandom_range(119) == 0)
        begin
            item.action = ACT_RESTART;
            item.wall_row = 4'($urandom_range(15));
            item.wall_col = 4'($urandom_range(15));
        end
        else if (roll < 85)
        begin
            if ($urandom_range(1) == 0)
            begin
                item.wall_row = 4'(2 * $urandom_range((SIDE - 1) / 2) + 1);
                item.wall_col = 4'(2 * $urandom_range(SIDE / 2, 1));
            end
            else
            begin
                item.wall_row = 4'(2 * $urandom_range(SIDE / 2, 1));
                item.wall_col = 4'(2 * $urandom_range((SIDE - 1) / 2) + 1);
            end
        end
        else
        begin
            item.wall_row = 4'($urandom_range(15));
            item.wall_col = 4'($urandom_range(15));
        end
        send_item(item);
    endtask

    task automatic wait_for_results();
        while (sb.results_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(ACT_RESTART, 0, 0);
        send_fields(ACT_OFFER, 0, 0);
        send_fields(ACT_OFFER, 15, 15);
        send_fields(ACT_OFFER, 14, 3);
        send_fields(ACT_OFFER, 3, 0);
        send_fields(ACT_OFFER, 1, 1);
        send_fields(ACT_OFFER, 2, 2);
        send_fields(ACT_OFFER, 13, 13);
        send_fields(ACT_OFFER, 1, 2);
        send_fields(ACT_OFFER, 1, 2);
        send_fields(ACT_OFFER, 2, 1);
        send_fields(ACT_OFFER, 2, 3);
        send_fields(ACT_OFFER, 3, 2);
        send_fields(ACT_OFFER, 12, 13);
        send_fields(ACT_OFFER, 13, 12);
        send_fields(ACT_OFFER, 12, 12);
        send_fields(ACT_RESTART, 15, 15);
        send_fields(ACT_OFFER, 1, 2);
        send_fields(ACT_OFFER, 7, 8);
        send_fields(ACT_OFFER, 8, 7);
        send_fields(ACT_RESTART, 10, 5);

        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_item();

        tx_idle_pct = 52;
        rx_idle_pct = 33;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
        begin
            if (i == RANDOM_PER_PHASE / 2)
            begin
                wall_valid <= 1'b0;
                wait_for_results();
                @(posedge clk);
            end
            send_random_item();
        end

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_item();
        wall_valid <= 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.results_due.size() == 0)
            $display("maze_wall_union_find_tb OK");
        else
            $display("maze_wall_union_find_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
